/* rtl/core/lpsd_pkg.sv */
// ----------------------------------------------------------------------------
// lpsd_pkg: shared types for the length-prefixed string list deframer
// Phase codes, result kinds, error codes and the result word layout.
// ----------------------------------------------------------------------------
package lpsd_pkg;

	localparam int FieldBytes = 8;
	localparam int FieldWidth = 64;

	typedef enum logic [1:0] {
		PH_COUNT   = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_CONTENT = 2'd2,
		PH_TAIL    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		K_DATA  = 2'd0,
		K_EMPTY = 2'd1,
		K_OK    = 2'd2,
		K_ERROR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		E_SMALL     = 2'd0,
		E_TRUNCATED = 2'd1,
		E_TOOLONG   = 2'd2
	} err_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       string_end;
		logic [1:0] error_code;
	} res_t;

	// up to two results per byte, packed toward slot 0
	typedef struct packed {
		logic v0;
		res_t r0;
		logic v1;
		res_t r1;
	} push_t;

endpackage

/* rtl/core/length_prefixed_string_list_deframer_unit.sv */
// ----------------------------------------------------------------------------
// length_prefixed_string_list_deframer_unit: deframer for a list of strings
// Splits a message of a 64-bit LE count and LE-length-prefixed strings into
// content bytes, empty-string markers and a final ok/error verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one message byte per word; s_tlast marks the last byte.
//   Master side gives one result per word: m_tuser is the kind (content
//   byte, empty string, ok, error), m_tdata carries the content byte and the
//   error code, m_tlast flags the last content byte of each string.
//   On an error the consumer drops the content already seen for that message.
// Path: an accepted byte is registered in the input stage, parsed from there,
//   and its results are written to the queue, whose head is the master side.
// Throughput: one byte per cycle; the parse stage fires whenever the result
//   queue has room for two words, so with a ready consumer the slave side
//   never stalls: a byte that gives two results leaves one extra word, which
//   drains while the first count byte of the next message is parsed.
// Reset: arst_n clears the phase, the field byte counter, the input stage
//   and the queue; the block then waits for the count of a new message.
// Stall: while m_tready is low the four-entry queue fills; once fewer than
//   two places are free the parse stage holds and s_tready drops.
// ----------------------------------------------------------------------------
module length_prefixed_string_list_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] error_code, rest zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // string_end
);

	// input stage
	logic            v_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;

	logic            step;
	logic            room2;
	logic            not_empty;
	logic [2:0]      q_count;
	lpsd_pkg::push_t push;
	lpsd_pkg::res_t  head;

	// parse fires when the queue can take a worst-case pair of results
	assign step     = v_s1 & room2;
	assign s_tready = ~v_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	lpsd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.is_last (last_s1),
		.push    (push)
	);

	lpsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2),
		.count     (q_count)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {6'd0, head.error_code, head.data_byte};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.string_end;

	// queue never overflows
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 3'd4)
		else $error("result queue overflow");

	// a held input byte stays put until parsed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !step |=> v_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a byte");

	// an accepted byte is in the input stage next cycle
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted byte not captured");

	// only content bytes carry the string-end flag
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == lpsd_pkg::K_DATA)
		else $error("string end on non-content result");

	// second result of a byte is always the verdict
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && (push.r1.kind == lpsd_pkg::K_OK ||
			push.r1.kind == lpsd_pkg::K_ERROR))
		else $error("bad result pair");

endmodule

/* rtl/core/lpsd_parse.sv */
// ----------------------------------------------------------------------------
// lpsd_parse: message parser
// Field collection, string/byte counters and end-of-message checks, one
// byte per step.
// ----------------------------------------------------------------------------
module lpsd_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                is_last,
	output lpsd_pkg::push_t     push
);

	localparam int FW = lpsd_pkg::FieldWidth;

	lpsd_pkg::phase_t phase_q, phase_d;
	logic [2:0]       idx_q, idx_d;
	logic [FW-1:0]    field_q, field_d;
	logic [FW-1:0]    strings_q, strings_d;
	logic [FW-1:0]    bytes_q, bytes_d;

	logic [FW-1:0]    shifted;
	logic             full;
	logic             main_v;
	lpsd_pkg::res_t   main_r;
	lpsd_pkg::res_t   fin_r;

	assign shifted = {in_byte, field_q[FW-1:8]};
	assign full    = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpsd_pkg::PH_COUNT;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			field_q   <= field_d;
			strings_q <= strings_d;
			bytes_q   <= bytes_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		field_d   = field_q;
		strings_d = strings_q;
		bytes_d   = bytes_q;
		main_v    = 1'b0;
		main_r    = '{lpsd_pkg::K_DATA, 8'd0, 1'b0, 2'd0};
		fin_r     = '{lpsd_pkg::K_OK, 8'd0, 1'b0, 2'd0};

		unique case (phase_q)
			lpsd_pkg::PH_COUNT: begin
				field_d = shifted;
				idx_d   = idx_q + 3'd1;
				if (full) begin
					strings_d = shifted;
					phase_d   = (shifted != '0) ? lpsd_pkg::PH_LENGTH : lpsd_pkg::PH_TAIL;
				end
			end
			lpsd_pkg::PH_LENGTH: begin
				field_d = shifted;
				idx_d   = idx_q + 3'd1;
				if (full) begin
					bytes_d = shifted;
					if (shifted == '0) begin
						main_v       = 1'b1;
						main_r.kind  = lpsd_pkg::K_EMPTY;
						strings_d    = strings_q - FW'(1);
						phase_d      = (strings_q != FW'(1)) ? lpsd_pkg::PH_LENGTH
						                                      : lpsd_pkg::PH_TAIL;
					end else begin
						phase_d = lpsd_pkg::PH_CONTENT;
					end
				end
			end
			lpsd_pkg::PH_CONTENT: begin
				bytes_d           = bytes_q - FW'(1);
				main_v            = 1'b1;
				main_r.data_byte  = in_byte;
				main_r.string_end = (bytes_q == FW'(1));
				if (bytes_q == FW'(1)) begin
					strings_d = strings_q - FW'(1);
					phase_d   = (strings_q != FW'(1)) ? lpsd_pkg::PH_LENGTH
					                                   : lpsd_pkg::PH_TAIL;
				end
			end
			lpsd_pkg::PH_TAIL: begin
			end
			default: begin
			end
		endcase

		// end-of-message verdict from where the byte left us
		unique case (phase_d)
			lpsd_pkg::PH_COUNT: begin
				fin_r.kind       = lpsd_pkg::K_ERROR;
				fin_r.error_code = lpsd_pkg::E_SMALL;
			end
			lpsd_pkg::PH_LENGTH: begin
				fin_r.kind       = lpsd_pkg::K_ERROR;
				fin_r.error_code = lpsd_pkg::E_TRUNCATED;
			end
			lpsd_pkg::PH_CONTENT: begin
				fin_r.kind       = lpsd_pkg::K_ERROR;
				fin_r.error_code = lpsd_pkg::E_TOOLONG;
			end
			default: begin
				fin_r.kind = lpsd_pkg::K_OK;
			end
		endcase

		if (is_last) begin
			phase_d = lpsd_pkg::PH_COUNT;
			idx_d   = '0;
		end

		push.v0 = step & (main_v | is_last);
		push.r0 = main_v ? main_r : fin_r;
		push.v1 = step & main_v & is_last;
		push.r1 = fin_r;
	end

endmodule

/* rtl/core/lpsd_queue.sv */
// ----------------------------------------------------------------------------
// lpsd_queue: result queue
// Four-entry register queue; takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
module lpsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  lpsd_pkg::push_t   push,
	input  logic              pop,
	output lpsd_pkg::res_t    head,
	output logic              not_empty,
	output logic              room2,
	output logic [2:0]        count
);

	lpsd_pkg::res_t mem_q [4];
	logic [1:0]     wr_q;
	logic [1:0]     rd_q;
	logic [2:0]     cnt_q;
	logic [2:0]     n_push;
	logic           do_pop;

	assign not_empty = (cnt_q != 3'd0);
	assign do_pop    = pop & not_empty;
	assign room2     = (cnt_q <= 3'd2);
	assign head      = mem_q[rd_q];
	assign count     = cnt_q;
	assign n_push    = {2'b00, push.v0} + {2'b00, push.v1};

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[1:0];
			rd_q  <= rd_q + {1'b0, do_pop};
			cnt_q <= cnt_q + n_push - {2'b00, do_pop};
		end
	end

endmodule
